// ----- hw/rtl/dit_pkg.sv -----
`timescale 1ns / 1ps

package dit_pkg;

  localparam int unsigned MAX_ENTRIES = 8;
  localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);

  // sub-function codes
  localparam logic [7:0] MODE_DEF_ID   = 8'd1;
  localparam logic [7:0] MODE_DEF_ADDR = 8'd2;
  localparam logic [7:0] MODE_CLEAR    = 8'd3;

  localparam logic [7:0] ADDR_FORMAT   = 8'h14;
  localparam logic [7:0] MIN_LEN_ID    = 8'd8;
  localparam logic [7:0] MIN_LEN_ADDR  = 8'd10;
  localparam logic [7:0] MIN_LEN_CLEAR = 8'd2;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_LENGTH      = 2'd1,
    ST_RANGE       = 2'd2,
    ST_UNSUPPORTED = 2'd3
  } status_t;

  // outcome of the first-look checks on a request
  typedef enum logic [2:0] {
    ACT_LEN,
    ACT_RANGE,
    ACT_UNSUP,
    ACT_APPEND,
    ACT_SCAN
  } act_t;

  typedef struct packed {
    logic    load;
    logic    scan_clr;
    logic    scan_step;
    logic    append;
    logic    copy;
    logic    set_status;
    status_t status;
    logic    out_load;
  } dit_cmd_t;

  typedef struct packed {
    act_t act;
    logic hit;
    logic scan_last;
    logic is_clear;
    logic out_busy;
  } dit_sts_t;

endpackage

// ----- hw/rtl/dit_if.sv -----
`timescale 1ns / 1ps

interface dit_req_if;
  logic        valid;
  logic        ready;
  logic [7:0]  mode;
  logic [7:0]  request_length;
  logic [15:0] dynamic_id;
  logic [15:0] source_id;
  logic [7:0]  source_position;
  logic [7:0]  data_size;
  logic [7:0]  format_code;
  logic [31:0] target_address;

  modport source (
    output valid, mode, request_length, dynamic_id, source_id,
           source_position, data_size, format_code, target_address,
    input  ready
  );
  modport sink (
    input  valid, mode, request_length, dynamic_id, source_id,
           source_position, data_size, format_code, target_address,
    output ready
  );
endinterface

interface dit_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  echoed_mode;
  logic [15:0] echoed_id;

  modport source (
    output valid, status, echoed_mode, echoed_id,
    input  ready
  );
  modport sink (
    input  valid, status, echoed_mode, echoed_id,
    output ready
  );
endinterface

// ----- hw/rtl/dit_ctrl.sv -----
`timescale 1ns / 1ps

module dit_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  dit_pkg::dit_sts_t sts,
  output dit_pkg::dit_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECODE = 5'b00010,
    S_SCAN   = 5'b00100,
    S_COPY   = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.status = dit_pkg::ST_OK;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next     = S_FINISH;
        cmd.set_status = 1'b1;
        case (sts.act)
          dit_pkg::ACT_LEN:    cmd.status = dit_pkg::ST_LENGTH;
          dit_pkg::ACT_RANGE:  cmd.status = dit_pkg::ST_RANGE;
          dit_pkg::ACT_UNSUP:  cmd.status = dit_pkg::ST_UNSUPPORTED;
          dit_pkg::ACT_APPEND: cmd.append = 1'b1;
          dit_pkg::ACT_SCAN: begin
            cmd.set_status = 1'b0;
            cmd.scan_clr   = 1'b1;
            state_next     = S_SCAN;
          end
          default: cmd.status = dit_pkg::ST_UNSUPPORTED;
        endcase
      end
      S_SCAN: begin
        if (sts.hit) begin
          if (sts.is_clear) begin
            state_next = S_COPY;
          end else begin
            // identifier already defined
            cmd.set_status = 1'b1;
            cmd.status     = dit_pkg::ST_RANGE;
            state_next     = S_FINISH;
          end
        end else if (sts.scan_last) begin
          cmd.set_status = 1'b1;
          state_next     = S_FINISH;
          if (sts.is_clear) begin
            cmd.status = dit_pkg::ST_RANGE;
          end else begin
            cmd.append = 1'b1;
          end
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_COPY: begin
        cmd.copy       = 1'b1;
        cmd.set_status = 1'b1;
        state_next     = S_FINISH;
      end
      S_FINISH: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- hw/rtl/dit_datapath.sv -----
`timescale 1ns / 1ps

module dit_datapath (
  input  logic              clk,
  input  logic              rst,
  dit_req_if.sink           req,
  dit_rsp_if.source         rsp,
  input  dit_pkg::dit_cmd_t cmd,
  output dit_pkg::dit_sts_t sts
);

  localparam int unsigned DEPTH = dit_pkg::MAX_ENTRIES;
  localparam int unsigned IW    = dit_pkg::IDX_W;
  localparam int unsigned CW    = dit_pkg::CNT_W;

  // captured request
  logic [7:0]  mode;
  logic [7:0]  req_len;
  logic [15:0] did;
  logic [15:0] src;
  logic [7:0]  pos;
  logic [7:0]  size;
  logic [7:0]  fmt;
  logic [31:0] addr;

  // table
  logic [15:0] entry_ident    [DEPTH];
  logic [15:0] entry_source   [DEPTH];
  logic [31:0] entry_position [DEPTH];
  logic [7:0]  entry_length   [DEPTH];
  logic [CW-1:0] count;
  logic [IW-1:0] idx;

  dit_pkg::status_t res_status;
  dit_pkg::act_t    act;

  logic          out_valid;
  logic [1:0]    out_status;
  logic [7:0]    out_mode;
  logic [15:0]   out_id;

  logic [CW-1:0] last_full;
  logic [IW-1:0] last;
  logic [IW-1:0] rd_idx;
  logic [IW-1:0] wr_idx;
  logic          full;
  logic          empty;
  logic [15:0]   wr_source;
  logic [31:0]   wr_position;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode    <= req.mode;
      req_len <= req.request_length;
      did     <= req.dynamic_id;
      src     <= req.source_id;
      pos     <= req.source_position;
      size    <= req.data_size;
      fmt     <= req.format_code;
      addr    <= req.target_address;
    end
  end

  assign last_full = count - CW'(1);
  assign last      = last_full[IW-1:0];
  assign full      = (count >= CW'(DEPTH));
  assign empty     = (count == '0);
  // one read port: the last slot while moving it, else the scan slot
  assign rd_idx    = cmd.copy ? last : idx;
  assign wr_idx    = cmd.copy ? idx : count[IW-1:0];

  always_comb begin
    if (mode == dit_pkg::MODE_DEF_ADDR) begin
      wr_source   = '0;
      wr_position = addr;
    end else begin
      wr_source   = src;
      wr_position = {24'd0, pos};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.append) begin
      entry_ident[wr_idx]    <= did;
      entry_source[wr_idx]   <= wr_source;
      entry_position[wr_idx] <= wr_position;
      entry_length[wr_idx]   <= size;
    end else if (cmd.copy) begin
      entry_ident[wr_idx]    <= entry_ident[rd_idx];
      entry_source[wr_idx]   <= entry_source[rd_idx];
      entry_position[wr_idx] <= entry_position[rd_idx];
      entry_length[wr_idx]   <= entry_length[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.append) begin
      count <= count + CW'(1);
    end else if (cmd.copy) begin
      count <= last_full;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_clr) begin
      idx <= '0;
    end else if (cmd.scan_step) begin
      idx <= idx + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_status) begin
      res_status <= cmd.status;
    end
  end

  // first-look checks, in the order the service defines them
  always_comb begin
    case (mode)
      dit_pkg::MODE_DEF_ID: begin
        if (req_len < dit_pkg::MIN_LEN_ID)    act = dit_pkg::ACT_LEN;
        else if (full)                        act = dit_pkg::ACT_RANGE;
        else if (empty)                       act = dit_pkg::ACT_APPEND;
        else                                  act = dit_pkg::ACT_SCAN;
      end
      dit_pkg::MODE_DEF_ADDR: begin
        if (req_len < dit_pkg::MIN_LEN_ADDR)  act = dit_pkg::ACT_LEN;
        else if (full)                        act = dit_pkg::ACT_RANGE;
        else if (fmt != dit_pkg::ADDR_FORMAT) act = dit_pkg::ACT_RANGE;
        else                                  act = dit_pkg::ACT_APPEND;
      end
      dit_pkg::MODE_CLEAR: begin
        if (req_len < dit_pkg::MIN_LEN_CLEAR) act = dit_pkg::ACT_LEN;
        else if (empty)                       act = dit_pkg::ACT_RANGE;
        else                                  act = dit_pkg::ACT_SCAN;
      end
      default: act = dit_pkg::ACT_UNSUP;
    endcase
  end

  assign sts.act       = act;
  assign sts.hit       = (entry_ident[rd_idx] == did);
  assign sts.scan_last = (CW'(idx) == last_full);
  assign sts.is_clear  = (mode == dit_pkg::MODE_CLEAR);
  assign sts.out_busy  = out_valid && !rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status <= res_status;
      out_mode   <= (res_status == dit_pkg::ST_OK) ? mode : 8'd0;
      out_id     <= (res_status == dit_pkg::ST_OK) ? did : 16'd0;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.echoed_mode = out_mode;
  assign rsp.echoed_id   = out_id;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above table depth");
  a_append_room: assert property (@(posedge clk) disable iff (rst)
    cmd.append |-> !full)
    else $error("append into a full table");
  a_copy_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.copy |-> !empty && (CW'(idx) < count))
    else $error("removal outside the valid entries");
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid)
    else $error("reply word not presented after load");
`endif

endmodule

// ----- hw/rtl/dynamic_identifier_table.sv -----
`timescale 1ns / 1ps

// Channel  Dir  Interface    Word
// req      in   dit_req_if   one request: sub-function, length, ids, position, size, address
// rsp      out  dit_rsp_if   one reply: status, echoed sub-function and id
//
// Steps: accept, decode, then for a scanning request a compare of each table
// entry in turn (up to MAX_ENTRIES), a move of the last entry on a clear that
// hits, and loading of the reply; a new request is taken only after that load.
// The entry scan runs through the single table read port.
// Reset (rst, synchronous) empties the table; entry contents are not cleared.
// A stalled reply holds in the output register; the next request is accepted
// while it waits, and only its own reply waits for the register to drain.

module dynamic_identifier_table (
  input  logic      clk,
  input  logic      rst,
  dit_req_if.sink   req,
  dit_rsp_if.source rsp
);

  dit_pkg::dit_cmd_t cmd;
  dit_pkg::dit_sts_t sts;

  // controller: sequencing of checks, scan, swap-remove and reply
  dit_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: request capture, entry table, count, reply register
  dit_datapath u_datapath (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cmd (cmd),
    .sts (sts)
  );

endmodule
